// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ST_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("st assertion failed");
`define ST_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("st assertion failed");
`else
`define ST_ASSERT(lbl, prop)
`define ST_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/st_pkg.sv =====
package st_pkg;

  typedef enum logic [4:0] {
    K_IDENT    = 5'd0,
    K_FUNC     = 5'd1,
    K_EXTERN   = 5'd2,
    K_LET      = 5'd3,
    K_VAR      = 5'd4,
    K_INT      = 5'd5,
    K_NONE     = 5'd6,
    K_CSTR     = 5'd7,
    K_STRING   = 5'd8,
    K_NUMBER   = 5'd9,
    K_COLEQ    = 5'd10,
    K_COLON    = 5'd11,
    K_ARROW    = 5'd12,
    K_SUB      = 5'd13,
    K_SEMI     = 5'd14,
    K_EQ       = 5'd15,
    K_OPAREN   = 5'd16,
    K_CPAREN   = 5'd17,
    K_OBRACE   = 5'd18,
    K_CBRACE   = 5'd19,
    K_ADD      = 5'd20,
    K_COMMA    = 5'd21,
    K_ELLIPSIS = 5'd22,
    K_MUL      = 5'd23,
    K_DIV      = 5'd24,
    K_EOF      = 5'd25,
    K_BAD      = 5'd26,
    K_UNTERM   = 5'd27
  } kind_t;

  // One byte can produce a pending token, a single-character token,
  // a flushed token and the end-of-input token; at most three are real.
  localparam int RESULT_SLOTS = 4;
  localparam int MAX_PER_ITEM = 3;
  localparam int QUEUE_DEPTH  = 8;

  localparam int KW_COUNT = 7;
  localparam logic [47:0] KW_WORD [KW_COUNT] = '{
    48'h0000_6675_6E63, 48'h6578_7465_726E, 48'h0000_006C_6574, 48'h0000_0076_6172,
    48'h0000_0069_6E74, 48'h0000_6E6F_6E65, 48'h0000_6373_7472
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd6, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
  };
  localparam kind_t KW_KIND [KW_COUNT] = '{
    K_FUNC, K_EXTERN, K_LET, K_VAR, K_INT, K_NONE, K_CSTR
  };

  function automatic kind_t name_kind(input logic [47:0] win, input logic [2:0] len);
    kind_t k;
    k = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && win == KW_WORD[i]) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/st_queue.sv =====
`include "assert_macros.svh"

module st_queue
  import st_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid [RESULT_SLOTS],
  input  logic [WIDTH-1:0] in_data  [RESULT_SLOTS],
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = $clog2(RESULT_SLOTS + 1);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  wr_idx [RESULT_SLOTS];
  logic [SLOT_W-1:0] nwrite;
  logic              pop;

  always_comb begin
    nwrite = '0;
    for (int i = 0; i < RESULT_SLOTS; i++) begin
      wr_idx[i] = wr_ptr + PTR_W'(nwrite);
      nwrite    = nwrite + SLOT_W'(in_valid[i]);
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign space     = (count <= CNT_W'(QUEUE_DEPTH - MAX_PER_ITEM));

  always_ff @(posedge clk) begin
    for (int i = 0; i < RESULT_SLOTS; i++) begin
      if (in_valid[i]) begin
        mem[wr_idx[i]] <= in_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(nwrite);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(nwrite) - CNT_W'(pop);
    end
  end

  `ST_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH))
  `ST_ASSERT(a_write_room, (nwrite != '0) |-> space)
  `ST_ASSERT(a_pop_only, (pop && nwrite == '0) |=> count == $past(count) - 1'b1)

endmodule

// ===== rtl/st_lexer.sv =====
`include "assert_macros.svh"

module st_lexer
  import st_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int OFFSET_BITS = 24,
  localparam int ENTRY_W    = 5 + LINE_BITS + 2 * COLUMN_BITS + OFFSET_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         source_byte,
  input  logic               final_byte,
  output logic               res_valid [RESULT_SLOTS],
  output logic [ENTRY_W-1:0] res_entry [RESULT_SLOTS]
);

  typedef enum logic [2:0] {
    M_IDLE, M_NAME, M_NUMBER, M_STRING, M_COLON, M_DASH, M_DOT1, M_DOT2
  } mode_t;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_OPAREN = 8'd40;
  localparam logic [7:0] CH_CPAREN = 8'd41;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_UNDER  = 8'd95;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_C = 8'd99;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_OBRACE = 8'd123;
  localparam logic [7:0] CH_CBRACE = 8'd125;

  localparam int SLOT_A = 0;
  localparam int SLOT_B = 1;
  localparam int SLOT_C = 2;
  localparam int SLOT_D = 3;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [LINE_BITS-1:0]   tok_line;
  logic [LINE_BITS-1:0]   tok_line_next;
  logic [COLUMN_BITS-1:0] tok_column;
  logic [COLUMN_BITS-1:0] tok_column_next;
  logic [OFFSET_BITS-1:0] tok_offset;
  logic [OFFSET_BITS-1:0] tok_offset_next;
  logic [47:0]            kw_window;
  logic [47:0]            kw_window_next;
  logic [2:0]             name_len;
  logic [2:0]             name_len_next;

  logic [LINE_BITS-1:0]   line_adv;
  logic [COLUMN_BITS-1:0] column_adv;
  logic [OFFSET_BITS-1:0] offset_adv;
  logic [COLUMN_BITS-1:0] endc_pre;
  logic [COLUMN_BITS-1:0] endc_post;

  logic                   is_alpha;
  logic                   is_digit;
  logic                   is_space;
  logic                   is_name;
  logic                   consumed;
  logic                   valid_a;
  logic                   valid_b;
  logic                   valid_c;
  kind_t                  kind_a;
  kind_t                  kind_b;
  kind_t                  kind_c;
  logic [COLUMN_BITS-1:0] endc_a;

  function automatic kind_t single_kind(input logic [7:0] ch);
    kind_t k;
    case (ch)
      CH_SEMI:   k = K_SEMI;
      CH_EQ:     k = K_EQ;
      CH_OPAREN: k = K_OPAREN;
      CH_CPAREN: k = K_CPAREN;
      CH_OBRACE: k = K_OBRACE;
      CH_CBRACE: k = K_CBRACE;
      CH_PLUS:   k = K_ADD;
      CH_COMMA:  k = K_COMMA;
      CH_STAR:   k = K_MUL;
      CH_SLASH:  k = K_DIV;
      default:   k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [ENTRY_W-1:0] pack_entry(
    input kind_t                  kind,
    input logic [LINE_BITS-1:0]   ln,
    input logic [COLUMN_BITS-1:0] col,
    input logic [COLUMN_BITS-1:0] endc,
    input logic [OFFSET_BITS-1:0] off,
    input logic                   last
  );
    return {last, off, endc, col, ln, kind};
  endfunction

  assign is_alpha = (source_byte >= CH_UPPER_A && source_byte <= CH_UPPER_Z) ||
                    (source_byte >= CH_LOWER_A && source_byte <= CH_LOWER_Z);
  assign is_digit = (source_byte >= CH_ZERO && source_byte <= CH_NINE);
  assign is_space = (source_byte == CH_SPACE) ||
                    (source_byte >= CH_TAB && source_byte <= CH_CR);
  assign is_name  = is_alpha || is_digit || (source_byte == CH_UNDER);

  // Every byte moves the position exactly once, saturating at the top.
  always_comb begin
    if (source_byte == CH_LF) begin
      line_adv   = (&line_count) ? line_count : line_count + 1'b1;
      column_adv = COLUMN_BITS'(1);
    end else begin
      line_adv   = line_count;
      column_adv = (&column_count) ? column_count : column_count + 1'b1;
    end
    offset_adv = (&byte_offset) ? byte_offset : byte_offset + 1'b1;
  end

  assign endc_pre  = column_count - 1'b1;
  assign endc_post = column_adv - 1'b1;

  always_comb begin
    mode_next       = mode;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    tok_offset_next = tok_offset;
    kw_window_next  = kw_window;
    name_len_next   = name_len;
    consumed        = 1'b0;
    valid_a         = 1'b0;
    kind_a          = K_IDENT;
    endc_a          = endc_pre;
    valid_b         = 1'b0;
    kind_b          = K_BAD;

    case (mode)
      M_NAME: begin
        if (is_name) begin
          consumed = 1'b1;
          if (name_len != 3'd7) begin
            name_len_next = name_len + 1'b1;
          end
          if (name_len < 3'd6) begin
            kw_window_next = {kw_window[39:0], source_byte};
          end
        end else if (source_byte == CH_QUOTE && name_len == 3'd1 &&
                     kw_window == 48'(CH_LOWER_C)) begin
          consumed        = 1'b1;
          mode_next       = M_STRING;
          tok_line_next   = line_adv;
          tok_column_next = column_adv;
          tok_offset_next = offset_adv;
        end else begin
          valid_a = 1'b1;
          kind_a  = name_kind(kw_window, name_len);
        end
      end
      M_NUMBER: begin
        if (is_digit) begin
          consumed = 1'b1;
        end else begin
          valid_a = 1'b1;
          kind_a  = K_NUMBER;
        end
      end
      M_STRING: begin
        consumed = 1'b1;
        if (source_byte == CH_QUOTE) begin
          valid_a   = 1'b1;
          kind_a    = K_STRING;
          endc_a    = endc_post;
          mode_next = M_IDLE;
        end
      end
      M_COLON: begin
        valid_a = 1'b1;
        if (source_byte == CH_EQ) begin
          consumed  = 1'b1;
          kind_a    = K_COLEQ;
          endc_a    = endc_post;
          mode_next = M_IDLE;
        end else begin
          kind_a = K_COLON;
        end
      end
      M_DASH: begin
        valid_a = 1'b1;
        if (source_byte == CH_GT) begin
          consumed  = 1'b1;
          kind_a    = K_ARROW;
          endc_a    = endc_post;
          mode_next = M_IDLE;
        end else begin
          kind_a = K_SUB;
        end
      end
      M_DOT1: begin
        if (source_byte == CH_DOT) begin
          consumed  = 1'b1;
          mode_next = M_DOT2;
        end else begin
          valid_a = 1'b1;
          kind_a  = K_BAD;
        end
      end
      M_DOT2: begin
        valid_a = 1'b1;
        if (source_byte == CH_DOT) begin
          consumed  = 1'b1;
          kind_a    = K_ELLIPSIS;
          endc_a    = endc_post;
          mode_next = M_IDLE;
        end else begin
          kind_a = K_BAD;
        end
      end
      default: begin
      end
    endcase

    // A byte that does not extend the pending token starts a new one.
    if (!consumed) begin
      mode_next = M_IDLE;
      if (!is_space) begin
        tok_line_next   = line_count;
        tok_column_next = column_count;
        tok_offset_next = byte_offset;
        if (is_alpha || source_byte == CH_UNDER) begin
          mode_next      = M_NAME;
          kw_window_next = 48'(source_byte);
          name_len_next  = 3'd1;
        end else if (is_digit) begin
          mode_next = M_NUMBER;
        end else if (source_byte == CH_COLON) begin
          mode_next = M_COLON;
        end else if (source_byte == CH_DASH) begin
          mode_next = M_DASH;
        end else if (source_byte == CH_DOT) begin
          mode_next = M_DOT1;
        end else begin
          valid_b = 1'b1;
          kind_b  = single_kind(source_byte);
        end
      end
    end
  end

  // On the final byte a token still open is flushed before end of input.
  always_comb begin
    valid_c = final_byte;
    case (mode_next)
      M_NAME:   kind_c = name_kind(kw_window_next, name_len_next);
      M_NUMBER: kind_c = K_NUMBER;
      M_STRING: kind_c = K_UNTERM;
      M_COLON:  kind_c = K_COLON;
      M_DASH:   kind_c = K_SUB;
      M_DOT1:   kind_c = K_BAD;
      M_DOT2:   kind_c = K_BAD;
      default: begin
        kind_c  = K_EOF;
        valid_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_valid[SLOT_A] = accept && valid_a;
    res_valid[SLOT_B] = accept && valid_b;
    res_valid[SLOT_C] = accept && valid_c;
    res_valid[SLOT_D] = accept && final_byte;
    res_entry[SLOT_A] = pack_entry(kind_a, tok_line, tok_column, endc_a, tok_offset,
                                   !valid_b && !final_byte);
    res_entry[SLOT_B] = pack_entry(kind_b, line_count, column_count, endc_post,
                                   byte_offset, !final_byte);
    res_entry[SLOT_C] = pack_entry(kind_c, tok_line_next, tok_column_next, endc_post,
                                   tok_offset_next, 1'b0);
    res_entry[SLOT_D] = pack_entry(K_EOF, line_adv, column_adv, column_adv,
                                   offset_adv, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      line_count   <= LINE_BITS'(1);
      column_count <= COLUMN_BITS'(1);
      byte_offset  <= '0;
      tok_line     <= '0;
      tok_column   <= '0;
      tok_offset   <= '0;
      kw_window    <= '0;
      name_len     <= '0;
    end else if (accept) begin
      tok_line   <= tok_line_next;
      tok_column <= tok_column_next;
      tok_offset <= tok_offset_next;
      if (final_byte) begin
        mode         <= M_IDLE;
        line_count   <= LINE_BITS'(1);
        column_count <= COLUMN_BITS'(1);
        byte_offset  <= '0;
        kw_window    <= '0;
        name_len     <= '0;
      end else begin
        mode         <= mode_next;
        line_count   <= line_adv;
        column_count <= column_adv;
        byte_offset  <= offset_adv;
        kw_window    <= kw_window_next;
        name_len     <= name_len_next;
      end
    end
  end

  `ST_ASSERT(a_final_restarts, (accept && final_byte) |=> (mode == M_IDLE && line_count == LINE_BITS'(1) && column_count == COLUMN_BITS'(1) && byte_offset == '0))
  `ST_ASSERT(a_at_most_three, accept |-> ($countones({res_valid[SLOT_A], res_valid[SLOT_B], res_valid[SLOT_C], res_valid[SLOT_D]}) <= 3))
  `ST_ASSERT(a_quiet_when_idle, !accept |-> !(res_valid[SLOT_A] || res_valid[SLOT_B] || res_valid[SLOT_C] || res_valid[SLOT_D]))

endmodule

// ===== rtl/source_tokenizer.sv =====
// Channel  Direction  Payload
// s_*      in         tdata = source_byte, tlast = final_byte
// m_*      out        tdata = start_line, start_column, end_column, start_offset;
//                     tuser = token_kind, tlast = last_of_run
//
// One source byte is taken per cycle while s_tready is high; its tokens land in the
// eight-entry result queue in the next cycle and leave one per cycle while m_tready is high.
// A byte yields zero to three tokens; s_tready drops while fewer than three
// queue entries are free, so a stalled m side backs up into the s side.
// Synchronous reset empties the queue and sets line 1, column 1, offset 0.
module source_tokenizer
  import st_pkg::*;
#(
  parameter int LINE_BITS    = 20,
  parameter int COLUMN_BITS  = 16,
  parameter int OFFSET_BITS  = 24,
  localparam int PAYLOAD_W   = LINE_BITS + 2 * COLUMN_BITS + OFFSET_BITS,
  localparam int DATA_W      = ((PAYLOAD_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // source_byte
  input  logic              s_tlast,   // final_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // start_line, start_column, end_column, start_offset
  output logic [4:0]        m_tuser,   // token_kind
  output logic              m_tlast    // last_of_run
);

  localparam int ENTRY_W = 5 + PAYLOAD_W + 1;

  logic               accept;
  logic               space;
  logic               res_valid [RESULT_SLOTS];
  logic [ENTRY_W-1:0] res_entry [RESULT_SLOTS];
  logic [ENTRY_W-1:0] out_entry;

  assign s_tready = space;
  assign accept   = s_tvalid && space;

  st_lexer #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .source_byte (s_tdata),
    .final_byte  (s_tlast),
    .res_valid   (res_valid),
    .res_entry   (res_entry)
  );

  st_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res_entry),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_entry)
  );

  assign m_tuser = out_entry[4:0];
  assign m_tdata = DATA_W'(out_entry[5 +: PAYLOAD_W]);
  assign m_tlast = out_entry[ENTRY_W-1];

endmodule
